// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the biquad filter checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the cycle after ante, outside reset.
`define XYBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xybq assertion failed: next-cycle check");

// Check that cons holds in the same cycle as ante, outside reset.
`define XYBQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xybq assertion failed: same-cycle check");

`endif

// ===== sv/xybq_pkg.sv =====
// ----------------------------------------------------------------------------
// xybq_pkg
// Shared constants, codes and control types of the X/Y biquad low-pass.
// ----------------------------------------------------------------------------
package xybq_pkg;

   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int COEF_FRAC_BITS_DEF = 14;

   localparam int COEF_W      = 18;
   localparam int HIST_W      = 24;
   localparam int PROD_W      = HIST_W + COEF_W;
   localparam int DIGIT_W     = 6;
   localparam int NUM_DIGITS  = COEF_W / DIGIT_W;
   localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);

   localparam int FB_TERMS   = 2;
   localparam int FF_TERMS   = 3;
   localparam int TERM_IDX_W = 2;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_B0    = 3'd0,
      REG_B1    = 3'd1,
      REG_B2    = 3'd2,
      REG_A1    = 3'd3,
      REG_A2    = 3'd4,
      REG_FORCE = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      OP_H0 = 2'd0,
      OP_H1 = 2'd1,
      OP_W  = 2'd2
   } op_sel_type;

   typedef enum logic [2:0] {
      CS_B0 = 3'd0,
      CS_B1 = 3'd1,
      CS_B2 = 3'd2,
      CS_A1 = 3'd3,
      CS_A2 = 3'd4
   } coef_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_FEEDBACK = 3'd1,
      ST_WSAT     = 3'd2,
      ST_FEEDFWD  = 3'd3,
      ST_FINISH   = 3'd4
   } seq_state_type;

   typedef struct packed {
      logic                   load;
      logic                   mac_en;
      logic                   subtract;
      logic                   w_latch;
      logic                   commit;
      logic [DIGIT_IDX_W-1:0] digit;
      op_sel_type             op_sel;
      coef_sel_type           coef_sel;
   } ctl_type;

   typedef struct packed {
      logic [COEF_W-1:0] b0;
      logic [COEF_W-1:0] b1;
      logic [COEF_W-1:0] b2;
      logic [COEF_W-1:0] a1;
      logic [COEF_W-1:0] a2;
      logic              force_bright;
   } coef_set_type;

endpackage

// ===== sv/xybq_req_if.sv =====
// ----------------------------------------------------------------------------
// xybq_req_if
// Input channel: one X/Y/intensity sample frame per item.
// ----------------------------------------------------------------------------
interface xybq_req_if #(
   parameter int SAMPLE_WIDTH = xybq_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] x_sample;
   logic signed [SAMPLE_WIDTH-1:0] y_sample;
   logic signed [SAMPLE_WIDTH-1:0] intensity_sample;

   modport source (output valid, x_sample, y_sample, intensity_sample, input ready);
   modport sink   (input valid, x_sample, y_sample, intensity_sample, output ready);
endinterface

// ===== sv/xybq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// xybq_rsp_if
// Result channel: one filtered X/Y/intensity frame per item.
// ----------------------------------------------------------------------------
interface xybq_rsp_if #(
   parameter int SAMPLE_WIDTH = xybq_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] x_filtered;
   logic signed [SAMPLE_WIDTH-1:0] y_filtered;
   logic signed [SAMPLE_WIDTH-1:0] intensity_out;

   modport source (output valid, x_filtered, y_filtered, intensity_out, input ready);
   modport sink   (input valid, x_filtered, y_filtered, intensity_out, output ready);
endinterface

// ===== sv/xy_biquad_lowpass.sv =====
// ----------------------------------------------------------------------------
// xy_biquad_lowpass
// Two-channel direct-form-II biquad low-pass for X/Y beam deflection samples.
// ----------------------------------------------------------------------------
// Each item carries signed X, Y and intensity samples (Q1.(SAMPLE_WIDTH-1)).
// X and Y run through their own biquad, both using the five shared Q4.14
// coefficients b0, b1, b2, a1, a2 from the register port; each keeps two
// 24-bit delay words that saturate on overflow, and the filtered outputs
// saturate to the sample width. Intensity passes through, or reads full scale
// when the brightness bit is set. One result item follows each input item.
// The X and Y lanes run side by side, each on its own digit-serial multiplier
// that takes one 6-bit coefficient digit per cycle. After accepting an item,
// the block steps through two feedback products, a delay-word saturation
// step, three feedforward products and a step that loads the result
// register, and only then takes the next item. A finished result waits in the
// output register while the next item is accepted; a stalled result
// only holds the block in its last step. Registers: b0 at 0x00, b1 at 0x04,
// b2 at 0x08, a1 at 0x0C, a2 at 0x10, brightness bit at 0x14; write them only
// while no item is in flight.
// ----------------------------------------------------------------------------
module xy_biquad_lowpass #(
   parameter int SAMPLE_WIDTH   = xybq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = xybq_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   xybq_req_if.sink                         req,
   xybq_rsp_if.source                       rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [xybq_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [xybq_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [xybq_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   localparam logic signed [SAMPLE_WIDTH-1:0] FULL_SCALE =
      {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};

   xybq_pkg::coef_set_type coefs;
   xybq_pkg::ctl_type      ctl;
   logic                   idle;
   logic                   req_fire;
   logic                   out_free;

   logic signed [xybq_pkg::COEF_W-1:0]                          coef_cur;
   logic [xybq_pkg::NUM_DIGITS-1:0][xybq_pkg::DIGIT_W-1:0]     coef_digits;
   logic signed [xybq_pkg::DIGIT_W:0]                           coef_digit;

   logic signed [SAMPLE_WIDTH-1:0] x_result, y_result;
   logic signed [SAMPLE_WIDTH-1:0] intensity_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] x_out_ff, y_out_ff, i_out_ff;

   // Register file.
   xybq_csr #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .coefs   (coefs)
   );

   // Accept a new item whenever the lanes are idle, even with a result waiting.
   assign req.ready = idle;
   assign req_fire  = req.valid && idle;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   xybq_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .out_free (out_free),
      .idle     (idle),
      .ctl      (ctl)
   );

   // Pick the coefficient for the current product, then its current digit.
   always_comb begin
      unique case (ctl.coef_sel)
         xybq_pkg::CS_B0: coef_cur = coefs.b0;
         xybq_pkg::CS_B1: coef_cur = coefs.b1;
         xybq_pkg::CS_B2: coef_cur = coefs.b2;
         xybq_pkg::CS_A1: coef_cur = coefs.a1;
         xybq_pkg::CS_A2: coef_cur = coefs.a2;
         default:         coef_cur = '0;
      endcase
   end

   // Lower digits are unsigned; the top digit carries the coefficient sign.
   assign coef_digits = coef_cur;
   always_comb begin
      if (ctl.digit == xybq_pkg::DIGIT_IDX_W'(xybq_pkg::NUM_DIGITS - 1)) begin
         coef_digit = {coef_cur[xybq_pkg::COEF_W-1], coef_digits[ctl.digit]};
      end else begin
         coef_digit = {1'b0, coef_digits[ctl.digit]};
      end
   end

   xybq_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_x (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sample_in  (req.x_sample),
      .coef_digit (coef_digit),
      .result     (x_result)
   );

   xybq_lane #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_lane_y (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sample_in  (req.y_sample),
      .coef_digit (coef_digit),
      .result     (y_result)
   );

   // Capture intensity at accept; it needs no filtering.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         intensity_ff <= coefs.force_bright ? FULL_SCALE : req.intensity_sample;
      end
   end

   // Output register: load on commit, drop valid once the item is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         x_out_ff <= x_result;
         y_out_ff <= y_result;
         i_out_ff <= intensity_ff;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.x_filtered    = x_out_ff;
   assign rsp.y_filtered    = y_out_ff;
   assign rsp.intensity_out = i_out_ff;

endmodule

// ===== sv/xybq_csr.sv =====
// ----------------------------------------------------------------------------
// xybq_csr
// APB-style register file holding the shared coefficients and brightness bit.
// ----------------------------------------------------------------------------
module xybq_csr #(
   parameter int COEF_FRAC_BITS = xybq_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [xybq_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [xybq_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [xybq_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output xybq_pkg::coef_set_type              coefs
);

   xybq_pkg::coef_set_type regs_ff;
   xybq_pkg::coef_set_type regs_in;
   xybq_pkg::reg_idx_type  idx;
   logic                   wr_en;

   assign idx    = xybq_pkg::reg_idx_type'(paddr[xybq_pkg::CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign coefs  = regs_ff;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         unique case (idx)
            xybq_pkg::REG_B0:    regs_in.b0 = pwdata[xybq_pkg::COEF_W-1:0];
            xybq_pkg::REG_B1:    regs_in.b1 = pwdata[xybq_pkg::COEF_W-1:0];
            xybq_pkg::REG_B2:    regs_in.b2 = pwdata[xybq_pkg::COEF_W-1:0];
            xybq_pkg::REG_A1:    regs_in.a1 = pwdata[xybq_pkg::COEF_W-1:0];
            xybq_pkg::REG_A2:    regs_in.a2 = pwdata[xybq_pkg::COEF_W-1:0];
            xybq_pkg::REG_FORCE: regs_in.force_bright = pwdata[0];
            default:             regs_in = regs_ff;
         endcase
      end
   end

   // Return coefficients sign-extended, the brightness bit zero-extended.
   always_comb begin
      unique case (idx)
         xybq_pkg::REG_B0:    prdata = xybq_pkg::CSR_DATA_W'($signed(regs_ff.b0));
         xybq_pkg::REG_B1:    prdata = xybq_pkg::CSR_DATA_W'($signed(regs_ff.b1));
         xybq_pkg::REG_B2:    prdata = xybq_pkg::CSR_DATA_W'($signed(regs_ff.b2));
         xybq_pkg::REG_A1:    prdata = xybq_pkg::CSR_DATA_W'($signed(regs_ff.a1));
         xybq_pkg::REG_A2:    prdata = xybq_pkg::CSR_DATA_W'($signed(regs_ff.a2));
         xybq_pkg::REG_FORCE: prdata = xybq_pkg::CSR_DATA_W'(regs_ff.force_bright);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.b0           <= xybq_pkg::COEF_W'(1 << COEF_FRAC_BITS);
         regs_ff.b1           <= '0;
         regs_ff.b2           <= '0;
         regs_ff.a1           <= '0;
         regs_ff.a2           <= '0;
         regs_ff.force_bright <= 1'b0;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

// ===== sv/xybq_seq.sv =====
// ----------------------------------------------------------------------------
// xybq_seq
// Sequencer: steps both filter lanes through the digit-serial products.
// ----------------------------------------------------------------------------
module xybq_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  logic              out_free,
   output logic              idle,
   output xybq_pkg::ctl_type ctl
);

   xybq_pkg::seq_state_type             state_ff, state_in;
   logic [xybq_pkg::DIGIT_IDX_W-1:0]    digit_ff, digit_in;
   logic [xybq_pkg::TERM_IDX_W-1:0]     term_ff, term_in;
   logic                                last_digit;

   assign last_digit = (digit_ff == xybq_pkg::DIGIT_IDX_W'(xybq_pkg::NUM_DIGITS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xybq_pkg::ST_IDLE;
         digit_ff <= '0;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         digit_ff <= digit_in;
         term_ff  <= term_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      digit_in     = digit_ff;
      term_in      = term_ff;
      idle         = 1'b0;
      ctl          = '0;
      ctl.digit    = digit_ff;
      ctl.op_sel   = xybq_pkg::OP_H0;
      ctl.coef_sel = xybq_pkg::CS_B0;
      unique case (state_ff)
         xybq_pkg::ST_IDLE: begin
            idle     = 1'b1;
            ctl.load = req_fire;
            if (req_fire) begin
               state_in = xybq_pkg::ST_FEEDBACK;
               digit_in = '0;
               term_in  = '0;
            end
         end
         xybq_pkg::ST_FEEDBACK: begin
            ctl.mac_en   = 1'b1;
            ctl.subtract = 1'b1;
            if (term_ff == '0) begin
               ctl.op_sel   = xybq_pkg::OP_H0;
               ctl.coef_sel = xybq_pkg::CS_A1;
            end else begin
               ctl.op_sel   = xybq_pkg::OP_H1;
               ctl.coef_sel = xybq_pkg::CS_A2;
            end
            if (last_digit) begin
               digit_in = '0;
               if (term_ff == xybq_pkg::TERM_IDX_W'(xybq_pkg::FB_TERMS - 1)) begin
                  term_in  = '0;
                  state_in = xybq_pkg::ST_WSAT;
               end else begin
                  term_in = term_ff + 1'b1;
               end
            end else begin
               digit_in = digit_ff + 1'b1;
            end
         end
         xybq_pkg::ST_WSAT: begin
            ctl.w_latch = 1'b1;
            state_in    = xybq_pkg::ST_FEEDFWD;
         end
         xybq_pkg::ST_FEEDFWD: begin
            ctl.mac_en = 1'b1;
            case (term_ff)
               2'd0: begin
                  ctl.op_sel   = xybq_pkg::OP_W;
                  ctl.coef_sel = xybq_pkg::CS_B0;
               end
               2'd1: begin
                  ctl.op_sel   = xybq_pkg::OP_H0;
                  ctl.coef_sel = xybq_pkg::CS_B1;
               end
               default: begin
                  ctl.op_sel   = xybq_pkg::OP_H1;
                  ctl.coef_sel = xybq_pkg::CS_B2;
               end
            endcase
            if (last_digit) begin
               digit_in = '0;
               if (term_ff == xybq_pkg::TERM_IDX_W'(xybq_pkg::FF_TERMS - 1)) begin
                  term_in  = '0;
                  state_in = xybq_pkg::ST_FINISH;
               end else begin
                  term_in = term_ff + 1'b1;
               end
            end else begin
               digit_in = digit_ff + 1'b1;
            end
         end
         xybq_pkg::ST_FINISH: begin
            if (out_free) begin
               ctl.commit = 1'b1;
               state_in   = xybq_pkg::ST_IDLE;
            end
         end
         default: state_in = xybq_pkg::ST_IDLE;
      endcase
   end

endmodule

// ===== sv/xybq_lane.sv =====
// ----------------------------------------------------------------------------
// xybq_lane
// One biquad channel: digit-serial multiply-accumulate, delay words, rounding.
// ----------------------------------------------------------------------------
module xybq_lane #(
   parameter int SAMPLE_WIDTH   = xybq_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = xybq_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  xybq_pkg::ctl_type                  ctl,
   input  logic signed [SAMPLE_WIDTH-1:0]     sample_in,
   input  logic signed [xybq_pkg::DIGIT_W:0]  coef_digit,
   output logic signed [SAMPLE_WIDTH-1:0]     result
);

   localparam int HIST_W = xybq_pkg::HIST_W;
   localparam int WIDE_W = (SAMPLE_WIDTH + COEF_FRAC_BITS > xybq_pkg::PROD_W) ?
                           SAMPLE_WIDTH + COEF_FRAC_BITS : xybq_pkg::PROD_W;
   localparam int ACC_W  = WIDE_W + 3;
   localparam int PART_W = HIST_W + xybq_pkg::DIGIT_W + 1;

   localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] HIST_MAX =
      {{(ACC_W - HIST_W + 1){1'b0}}, {(HIST_W - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] HIST_MIN = ~HIST_MAX;
   localparam logic signed [ACC_W-1:0] SAMP_MAX =
      {{(ACC_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAMP_MIN = ~SAMP_MAX;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [HIST_W-1:0] w_ff, w_in;
   logic signed [HIST_W-1:0] h0_ff, h1_ff;
   logic signed [HIST_W-1:0] operand;
   logic signed [PART_W-1:0] partial;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  rnd;

   always_comb begin
      unique case (ctl.op_sel)
         xybq_pkg::OP_H0: operand = h0_ff;
         xybq_pkg::OP_H1: operand = h1_ff;
         xybq_pkg::OP_W:  operand = w_ff;
         default:         operand = '0;
      endcase
   end

   // One coefficient digit per cycle, weighted by its digit position.
   assign partial = operand * coef_digit;
   assign term    = ACC_W'(partial) <<< (xybq_pkg::DIGIT_W * int'(ctl.digit));

   // Round half up, then floor shift.
   assign rnd = (acc_ff + RND_BIAS) >>> COEF_FRAC_BITS;

   always_comb begin
      if (rnd > HIST_MAX) begin
         w_in = HIST_W'(HIST_MAX);
      end else if (rnd < HIST_MIN) begin
         w_in = HIST_W'(HIST_MIN);
      end else begin
         w_in = HIST_W'(rnd);
      end
      if (rnd > SAMP_MAX) begin
         result = SAMPLE_WIDTH'(SAMP_MAX);
      end else if (rnd < SAMP_MIN) begin
         result = SAMPLE_WIDTH'(SAMP_MIN);
      end else begin
         result = SAMPLE_WIDTH'(rnd);
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctl.load) begin
         acc_in = ACC_W'(sample_in) <<< COEF_FRAC_BITS;
      end else if (ctl.w_latch) begin
         acc_in = '0;
      end else if (ctl.mac_en) begin
         acc_in = ctl.subtract ? (acc_ff - term) : (acc_ff + term);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctl.w_latch) begin
         w_ff <= w_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h0_ff <= '0;
         h1_ff <= '0;
      end else if (ctl.commit) begin
         h1_ff <= h0_ff;
         h0_ff <= w_ff;
      end
   end

endmodule

// ===== sv/xybq_checker.sv =====
// ----------------------------------------------------------------------------
// xybq_checker
// Port-level assertions for the X/Y biquad low-pass, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xybq_checker #(
   parameter int SAMPLE_WIDTH = xybq_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] x_filtered,
   input logic [SAMPLE_WIDTH-1:0] y_filtered,
   input logic [SAMPLE_WIDTH-1:0] intensity_out
);

   logic req_fire;
   logic rsp_stall;

   assign req_fire  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // A stalled result keeps its valid and its payload.
   `XYBQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `XYBQ_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(x_filtered) && $stable(y_filtered) && $stable(intensity_out))
   // One item at a time: the input closes right after an accept.
   `XYBQ_ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, !req_ready)
   // A result never appears the cycle after an accept.
   `XYBQ_ASSERT_NEXT(a_no_early_rsp, clock, reset, req_fire, !$rose(rsp_valid))

endmodule

bind xy_biquad_lowpass xybq_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_xybq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .x_filtered    (rsp.x_filtered),
   .y_filtered    (rsp.y_filtered),
   .intensity_out (rsp.intensity_out)
);
